// File: hw/rtl/ptli_pkg.sv
// Package: constants, types and codes shared by the periodic table interpolator.
package ptli_pkg;

   localparam int MAX_MODELS  = 4;
   localparam int MAX_ROWS    = 128;
   localparam int COEF_BITS   = 24;
   localparam int MODEL_BITS  = $clog2(MAX_MODELS);
   localparam int ROW_BITS    = $clog2(MAX_ROWS);
   localparam int ADDR_BITS   = MODEL_BITS + ROW_BITS;
   localparam int TABLE_DEPTH = MAX_MODELS * MAX_ROWS;
   localparam int ROW_WIDTH   = 3 * COEF_BITS;

   localparam int MCOUNT_BITS = 3;
   localparam int RCOUNT_BITS = 8;
   localparam int ANGLE_BITS  = 32;
   localparam int ANG_BITS    = 17;
   localparam int LAST_BITS   = ANG_BITS + RCOUNT_BITS;
   localparam int STATUS_BITS = 2;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 17;

   localparam logic [ANG_BITS-1:0] FULL_TURN = ANG_BITS'(92160);

   // angle mod 92160: low 11 bits pass, the upper part is reduced mod 45
   localparam int TURN_LO_BITS = 11;
   localparam int TURN_HI_BITS = ANGLE_BITS - TURN_LO_BITS;
   localparam int TURN_HI      = 45;
   localparam int MAGIC_BITS   = 27;
   localparam int MAGIC_SHIFT  = 32;
   localparam int QHI_BITS     = 16;
   localparam int REM45_BITS   = 6;
   localparam logic [MAGIC_BITS-1:0] MOD_MAGIC = MAGIC_BITS'(95443718);
   localparam logic [ANG_BITS-1:0]   BIAS_MOD  = ANG_BITS'(63488);
   localparam logic [ANG_BITS-1:0]   BIAS_FIX  = ANG_BITS'(28672);

   localparam int IDX_DIV_BITS = ANG_BITS + ROW_BITS;
   localparam int QUO_BITS     = COEF_BITS;
   localparam int PROD_BITS    = COEF_BITS + ANG_BITS + 1;

   localparam int QDEPTH    = 4;
   localparam int QPTR_BITS = $clog2(QDEPTH);
   localparam int QCNT_BITS = QPTR_BITS + 1;

   localparam logic FN_WRITE  = 1'b0;
   localparam logic FN_LOOKUP = 1'b1;

   localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_MODEL = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_ROW   = 2'd2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_MODELS = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ROWS   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STEP   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_START  = 3'd3;

   typedef enum logic [1:0] {
      CLS_BELOW,
      CLS_SEG,
      CLS_WRAP
   } cls_type;

   typedef struct packed {
      logic [MCOUNT_BITS-1:0] models;
      logic [RCOUNT_BITS-1:0] rows;
      logic [ANG_BITS-1:0]    step;
      logic [ANG_BITS-1:0]    start;
      logic [LAST_BITS-1:0]   last;
   } cfg_type;

   typedef struct packed {
      logic                              func;
      logic [MODEL_BITS-1:0]             model;
      logic [ROW_BITS-1:0]               row;
      logic [2:0][COEF_BITS-1:0]         coef;
      logic [STATUS_BITS-1:0]            status;
      logic [ROW_BITS-1:0]               row_a;
      logic [ROW_BITS-1:0]               row_b;
      logic [ANG_BITS-1:0]               num;
      logic [ANG_BITS-1:0]               den;
   } qitem_type;

endpackage

// File: hw/rtl/ptli_ram.sv
// Generic simple RAM: one write port, two registered read ports.
module ptli_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_a <= mem[raddr_a];
         rdata_b <= mem[raddr_b];
      end
   end
endmodule

// File: hw/rtl/ptli_front.sv
// Front end: accepts items, reduces the angle, classifies it and finds the row index.
module ptli_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ptli_pkg::cfg_type                    cfg,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic                                 req_func,
   input  logic [ptli_pkg::MODEL_BITS-1:0]      req_model_index,
   input  logic [ptli_pkg::ROW_BITS-1:0]        req_row_index,
   input  logic signed [ptli_pkg::COEF_BITS-1:0] req_lift_in,
   input  logic signed [ptli_pkg::COEF_BITS-1:0] req_drag_in,
   input  logic signed [ptli_pkg::COEF_BITS-1:0] req_moment_in,
   input  logic signed [ptli_pkg::ANGLE_BITS-1:0] req_angle,
   input  logic                                 q_full,
   output logic                                 q_push,
   output ptli_pkg::qitem_type                  q_item
);
   import ptli_pkg::*;

   typedef struct packed {
      logic                      valid;
      logic                      func;
      logic [MODEL_BITS-1:0]     model;
      logic [ROW_BITS-1:0]       row;
      logic [2:0][COEF_BITS-1:0] coef;
      logic [STATUS_BITS-1:0]    status;
   } side_type;

   logic front_en;

   side_type                   s1_ff, s1_in;
   logic [ANGLE_BITS-1:0]      angle1_ff;
   side_type                   s2_ff, s2_in;
   logic [TURN_HI_BITS-1:0]    qhi2_ff;
   logic [TURN_LO_BITS-1:0]    low2_ff;
   logic [QHI_BITS-1:0]        t2_ff, t2_in;
   side_type                   s3_ff;
   logic [ANG_BITS-1:0]        ang3_ff, ang3_in;

   side_type                   dv_ff [IDX_DIV_BITS-IDX_DIV_BITS+ROW_BITS+1];
   logic [ANG_BITS-1:0]        dr_ff [ROW_BITS+1];
   logic [ANG_BITS-1:0]        dr_in [ROW_BITS+1];
   logic [ROW_BITS-1:0]        dq_ff [ROW_BITS+1];
   logic [ROW_BITS-1:0]        dq_in [ROW_BITS+1];
   cls_type                    dc_ff [ROW_BITS+1];
   cls_type                    cls_in;
   logic [ANG_BITS-1:0]        dwn_ff [ROW_BITS+1];
   logic [ANG_BITS-1:0]        dwd_ff [ROW_BITS+1];
   logic [ANG_BITS-1:0]        wnum_in, wden_in;

   side_type                   last_side;

   assign last_side = dv_ff[ROW_BITS];
   assign front_en  = !(last_side.valid && q_full);
   assign req_full  = !front_en;
   assign q_push    = last_side.valid && !q_full;

   // stage 1 capture and stage 2 status plus reciprocal multiply
   always_comb begin
      logic [TURN_HI_BITS+MAGIC_BITS-1:0] prod;
      logic [ANGLE_BITS-1:0]              u;
      s1_in.valid  = req_push && front_en;
      s1_in.func   = req_func;
      s1_in.model  = req_model_index;
      s1_in.row    = req_row_index;
      s1_in.coef   = {req_moment_in, req_drag_in, req_lift_in};
      s1_in.status = ST_OK;

      s2_in = s1_ff;
      if ({1'b0, s1_ff.model} >= cfg.models) begin
         s2_in.status = ST_MODEL;
      end else if (s1_ff.func == FN_WRITE) begin
         if ({1'b0, s1_ff.row} >= cfg.rows) begin
            s2_in.status = ST_ROW;
         end
      end else if (cfg.rows == '0 || cfg.rows > RCOUNT_BITS'(MAX_ROWS)) begin
         s2_in.status = ST_ROW;
      end
      u     = angle1_ff ^ {1'b1, {(ANGLE_BITS-1){1'b0}}};
      prod  = u[ANGLE_BITS-1:TURN_LO_BITS] * MOD_MAGIC;
      t2_in = prod[MAGIC_SHIFT +: QHI_BITS];
   end

   // stage 3: remainder mod 45, then undo the sign bias
   always_comb begin
      logic [TURN_HI_BITS-1:0] r45;
      logic [ANG_BITS-1:0]     r;
      r45 = qhi2_ff - TURN_HI_BITS'(t2_ff * TURN_HI_BITS'(TURN_HI));
      r   = {r45[REM45_BITS-1:0], low2_ff};
      if (r >= BIAS_MOD) begin
         ang3_in = r - BIAS_MOD;
      end else begin
         ang3_in = r + BIAS_FIX;
      end
   end

   // classification against start and last row angle
   always_comb begin
      if (ang3_ff < cfg.start) begin
         cls_in = CLS_BELOW;
      end else if (LAST_BITS'(ang3_ff) <= cfg.last) begin
         cls_in = CLS_SEG;
      end else begin
         cls_in = CLS_WRAP;
      end
      wnum_in = ang3_ff - cfg.last[ANG_BITS-1:0];
      wden_in = FULL_TURN - cfg.last[ANG_BITS-1:0];
   end

   // restoring division of the offset by step, one quotient bit per stage
   always_comb begin
      logic [IDX_DIV_BITS-1:0] sh;
      dr_in[0] = ang3_ff - cfg.start;
      dq_in[0] = '0;
      for (int k = 0; k < ROW_BITS; k++) begin
         sh = IDX_DIV_BITS'(cfg.step) << (ROW_BITS - 1 - k);
         if (IDX_DIV_BITS'(dr_ff[k]) >= sh) begin
            dr_in[k+1] = dr_ff[k] - sh[ANG_BITS-1:0];
            dq_in[k+1] = dq_ff[k] | (ROW_BITS'(1) << (ROW_BITS - 1 - k));
         end else begin
            dr_in[k+1] = dr_ff[k];
            dq_in[k+1] = dq_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
         for (int k = 0; k <= ROW_BITS; k++) begin
            dv_ff[k].valid <= 1'b0;
         end
      end else if (front_en) begin
         s1_ff     <= s1_in;
         angle1_ff <= req_angle;
         s2_ff     <= s2_in;
         qhi2_ff   <= angle1_ff[ANGLE_BITS-1:TURN_LO_BITS] ^ {1'b1, {(TURN_HI_BITS-1){1'b0}}};
         low2_ff   <= angle1_ff[TURN_LO_BITS-1:0];
         t2_ff     <= t2_in;
         s3_ff     <= s2_ff;
         ang3_ff   <= ang3_in;
         dv_ff[0]  <= s3_ff;
         dr_ff[0]  <= dr_in[0];
         dq_ff[0]  <= dq_in[0];
         dc_ff[0]  <= cls_in;
         dwn_ff[0] <= wnum_in;
         dwd_ff[0] <= wden_in;
         for (int k = 0; k < ROW_BITS; k++) begin
            dv_ff[k+1]  <= dv_ff[k];
            dr_ff[k+1]  <= dr_in[k+1];
            dq_ff[k+1]  <= dq_in[k+1];
            dc_ff[k+1]  <= dc_ff[k];
            dwn_ff[k+1] <= dwn_ff[k];
            dwd_ff[k+1] <= dwd_ff[k];
         end
      end
   end

   // queue item: the two rows to blend and the fraction between them
   always_comb begin
      logic [ROW_BITS-1:0]    idx;
      logic [ROW_BITS-1:0]    last_row;
      logic [RCOUNT_BITS-1:0] nxt;
      idx      = dq_ff[ROW_BITS];
      nxt      = RCOUNT_BITS'(idx) + RCOUNT_BITS'(1);
      last_row = ROW_BITS'(cfg.rows - RCOUNT_BITS'(1));
      q_item.func   = last_side.func;
      q_item.model  = last_side.model;
      q_item.row    = last_side.row;
      q_item.coef   = last_side.coef;
      q_item.status = last_side.status;
      q_item.row_a  = '0;
      q_item.row_b  = '0;
      q_item.num    = '0;
      q_item.den    = ANG_BITS'(1);
      if (last_side.func == FN_LOOKUP) begin
         unique case (dc_ff[ROW_BITS])
            CLS_SEG: begin
               q_item.row_a = idx;
               q_item.row_b = (nxt < cfg.rows) ? nxt[ROW_BITS-1:0] : idx;
               q_item.num   = dr_ff[ROW_BITS];
               q_item.den   = cfg.step;
            end
            CLS_WRAP: begin
               q_item.row_a = last_row;
               q_item.num   = dwn_ff[ROW_BITS];
               q_item.den   = dwd_ff[ROW_BITS];
            end
            default: begin
               q_item.row_a = '0;
            end
         endcase
      end
   end
endmodule

// File: hw/rtl/ptli_queue.sv
// Short item queue between the front end and the back end.
module ptli_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ptli_pkg::qitem_type push_item,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output ptli_pkg::qitem_type head
);
   import ptli_pkg::*;

   qitem_type              slot_ff [QDEPTH];
   logic [QPTR_BITS-1:0]   wr_ff, wr_in;
   logic [QPTR_BITS-1:0]   rd_ff, rd_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;

   assign full  = count_ff == QCNT_BITS'(QDEPTH);
   assign empty = count_ff == '0;
   assign head  = slot_ff[rd_ff];

   always_comb begin
      wr_in    = push ? wr_ff + QPTR_BITS'(1) : wr_ff;
      rd_in    = pop ? rd_ff + QPTR_BITS'(1) : rd_ff;
      count_in = count_ff + QCNT_BITS'(push) - QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != QCNT_BITS'(QDEPTH)))
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("queue pop while empty");
   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff != QCNT_BITS'(QDEPTH)) |-> ((wr_ff - rd_ff) == count_ff[QPTR_BITS-1:0]))
      else $error("queue pointers disagree with count");
endmodule

// File: hw/rtl/ptli_back.sv
// Back end: table writes and reads, blend multiply, rounding divide, result register.
module ptli_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  q_empty,
   input  ptli_pkg::qitem_type                   q_head,
   output logic                                  q_pop,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic signed [ptli_pkg::COEF_BITS-1:0] rsp_lift,
   output logic signed [ptli_pkg::COEF_BITS-1:0] rsp_drag,
   output logic signed [ptli_pkg::COEF_BITS-1:0] rsp_moment,
   output logic [ptli_pkg::STATUS_BITS-1:0]      rsp_status
);
   import ptli_pkg::*;

   typedef struct packed {
      logic                       valid;
      logic                       func;
      logic [STATUS_BITS-1:0]     status;
      logic [ANG_BITS-1:0]        den;
      logic [2:0][COEF_BITS-1:0]  y0;
      logic [2:0]                 neg;
      logic [2:0][PROD_BITS-1:0]  rem;
      logic [2:0][QUO_BITS-1:0]   quo;
   } div_type;

   logic                       back_en;
   logic [ROW_WIDTH-1:0]       rdata_a, rdata_b;

   logic                       v1_ff, f1_ff;
   logic [STATUS_BITS-1:0]     st1_ff;
   logic [ANG_BITS-1:0]        num1_ff, den1_ff;

   logic                       v2_ff, f2_ff;
   logic [STATUS_BITS-1:0]     st2_ff;
   logic [ANG_BITS-1:0]        num2_ff, den2_ff;
   logic [2:0][COEF_BITS-1:0]  y02_ff;
   logic [2:0]                 neg2_ff, neg2_in;
   logic [2:0][COEF_BITS-1:0]  abs2_ff, abs2_in;

   div_type                    dv_ff [QUO_BITS+1];
   div_type                    dv_in [QUO_BITS+1];

   logic                       out_valid_ff;
   logic [2:0][COEF_BITS-1:0]  out_ff, out_in;
   logic [STATUS_BITS-1:0]     out_st_ff;

   assign back_en   = !out_valid_ff || rsp_pop;
   assign q_pop     = !q_empty && back_en;
   assign rsp_empty = !out_valid_ff;
   assign rsp_lift   = out_ff[0];
   assign rsp_drag   = out_ff[1];
   assign rsp_moment = out_ff[2];
   assign rsp_status = out_st_ff;

   ptli_ram #(
      .WIDTH (ROW_WIDTH),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .we      (q_pop && q_head.func == FN_WRITE && q_head.status == ST_OK),
      .waddr   ({q_head.model, q_head.row}),
      .wdata   (q_head.coef),
      .re      (back_en),
      .raddr_a ({q_head.model, q_head.row_a}),
      .raddr_b ({q_head.model, q_head.row_b}),
      .rdata_a (rdata_a),
      .rdata_b (rdata_b)
   );

   // difference of the two rows, as sign and magnitude
   always_comb begin
      logic signed [COEF_BITS:0] d;
      for (int l = 0; l < 3; l++) begin
         d = $signed({rdata_b[l*COEF_BITS+COEF_BITS-1], rdata_b[l*COEF_BITS +: COEF_BITS]})
           - $signed({rdata_a[l*COEF_BITS+COEF_BITS-1], rdata_a[l*COEF_BITS +: COEF_BITS]});
         neg2_in[l] = d[COEF_BITS];
         abs2_in[l] = d[COEF_BITS] ? COEF_BITS'(-d) : d[COEF_BITS-1:0];
      end
   end

   // product plus half the divisor, then one quotient bit per stage
   always_comb begin
      logic [PROD_BITS-1:0] sh;
      dv_in[0].valid  = v2_ff;
      dv_in[0].func   = f2_ff;
      dv_in[0].status = st2_ff;
      dv_in[0].den    = den2_ff;
      dv_in[0].y0     = y02_ff;
      dv_in[0].neg    = neg2_ff;
      dv_in[0].quo    = '0;
      for (int l = 0; l < 3; l++) begin
         dv_in[0].rem[l] = PROD_BITS'(abs2_ff[l]) * PROD_BITS'(num2_ff)
                         + PROD_BITS'(den2_ff >> 1);
      end
      for (int k = 0; k < QUO_BITS; k++) begin
         dv_in[k+1] = dv_ff[k];
         sh = PROD_BITS'(dv_ff[k].den) << (QUO_BITS - 1 - k);
         for (int l = 0; l < 3; l++) begin
            if (dv_ff[k].rem[l] >= sh) begin
               dv_in[k+1].rem[l] = dv_ff[k].rem[l] - sh;
               dv_in[k+1].quo[l] = dv_ff[k].quo[l] | (QUO_BITS'(1) << (QUO_BITS - 1 - k));
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         if (dv_ff[QUO_BITS].func == FN_LOOKUP && dv_ff[QUO_BITS].status == ST_OK) begin
            out_in[l] = dv_ff[QUO_BITS].neg[l]
                      ? dv_ff[QUO_BITS].y0[l] - dv_ff[QUO_BITS].quo[l]
                      : dv_ff[QUO_BITS].y0[l] + dv_ff[QUO_BITS].quo[l];
         end else begin
            out_in[l] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k <= QUO_BITS; k++) begin
            dv_ff[k].valid <= 1'b0;
         end
      end else if (back_en) begin
         v1_ff   <= q_pop;
         f1_ff   <= q_head.func;
         st1_ff  <= q_head.status;
         num1_ff <= q_head.num;
         den1_ff <= q_head.den;
         v2_ff   <= v1_ff;
         f2_ff   <= f1_ff;
         st2_ff  <= st1_ff;
         num2_ff <= num1_ff;
         den2_ff <= den1_ff;
         y02_ff  <= rdata_a;
         neg2_ff <= neg2_in;
         abs2_ff <= abs2_in;
         for (int k = 0; k <= QUO_BITS; k++) begin
            dv_ff[k] <= dv_in[k];
         end
         out_valid_ff <= dv_ff[QUO_BITS].valid;
         out_ff       <= out_in;
         out_st_ff    <= dv_ff[QUO_BITS].status;
      end
   end
endmodule

// File: hw/rtl/periodic_table_linear_interpolator_top.sv
// Top level: configuration registers, front end, item queue and back end.
//
//  channel | handshake              | payload
//  req     | req_push / req_full    | func, model and row index, three coefficients, angle
//  rsp     | rsp_pop / rsp_empty    | lift, drag, moment, status
//  csr     | csr_valid / csr_ready  | csr_index, csr_wdata
//
// One item per cycle sustained while results are popped; results pass the seven-stage
// row index divider in front and the 24-stage rounding divider in back.
// Synchronous active-high reset clears all valid bits and pointers and sets the config
// defaults; data is not reset. A stalled result stops only the back end; the front keeps
// taking items until the four-entry queue and its own last stage fill, then req_full rises.
module periodic_table_linear_interpolator_top (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_push,
   output logic                                    req_full,
   input  logic                                    req_func,
   input  logic [ptli_pkg::MODEL_BITS-1:0]         req_model_index,
   input  logic [ptli_pkg::ROW_BITS-1:0]           req_row_index,
   input  logic signed [ptli_pkg::COEF_BITS-1:0]   req_lift_in,
   input  logic signed [ptli_pkg::COEF_BITS-1:0]   req_drag_in,
   input  logic signed [ptli_pkg::COEF_BITS-1:0]   req_moment_in,
   input  logic signed [ptli_pkg::ANGLE_BITS-1:0]  req_angle,
   output logic                                    rsp_empty,
   input  logic                                    rsp_pop,
   output logic signed [ptli_pkg::COEF_BITS-1:0]   rsp_lift,
   output logic signed [ptli_pkg::COEF_BITS-1:0]   rsp_drag,
   output logic signed [ptli_pkg::COEF_BITS-1:0]   rsp_moment,
   output logic [ptli_pkg::STATUS_BITS-1:0]        rsp_status,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [ptli_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [ptli_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);
   import ptli_pkg::*;

   logic [MCOUNT_BITS-1:0] models_ff;
   logic [RCOUNT_BITS-1:0] rows_ff;
   logic [ANG_BITS-1:0]    step_ff;
   logic [ANG_BITS-1:0]    start_ff;
   logic [ANG_BITS-1:0]    step_eff;
   logic [LAST_BITS-1:0]   last_ff, last_in;
   cfg_type                cfg;

   logic       q_push, q_full, q_pop, q_empty;
   qitem_type  q_in_item, q_head;

   assign csr_ready = 1'b1;
   assign step_eff  = (step_ff == '0) ? ANG_BITS'(1) : step_ff;
   assign last_in   = LAST_BITS'(start_ff)
                    + LAST_BITS'(rows_ff - RCOUNT_BITS'(1)) * LAST_BITS'(step_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         models_ff <= MCOUNT_BITS'(1);
         rows_ff   <= RCOUNT_BITS'(73);
         step_ff   <= ANG_BITS'(1280);
         start_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MODELS: models_ff <= csr_wdata[MCOUNT_BITS-1:0];
            CSR_ROWS:   rows_ff   <= csr_wdata[RCOUNT_BITS-1:0];
            CSR_STEP:   step_ff   <= csr_wdata[ANG_BITS-1:0];
            CSR_START:  start_ff  <= csr_wdata[ANG_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
   end

   always_comb begin
      cfg.models = models_ff;
      cfg.rows   = rows_ff;
      cfg.step   = step_eff;
      cfg.start  = start_ff;
      cfg.last   = last_ff;
   end

   ptli_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_func        (req_func),
      .req_model_index (req_model_index),
      .req_row_index   (req_row_index),
      .req_lift_in     (req_lift_in),
      .req_drag_in     (req_drag_in),
      .req_moment_in   (req_moment_in),
      .req_angle       (req_angle),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_item          (q_in_item)
   );

   ptli_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   ptli_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_lift   (rsp_lift),
      .rsp_drag   (rsp_drag),
      .rsp_moment (rsp_moment),
      .rsp_status (rsp_status)
   );
endmodule
